// ===== rtl/ett_pkg.sv =====
package ett_pkg;

    localparam int ETT_TABLE_TOP = 1023;
    localparam int ETT_FIELD_W   = 10;
    localparam int ETT_STEP_W    = 4;

    // memory operation of a step
    localparam logic [1:0] MEM_NONE = 2'd0;
    localparam logic [1:0] MEM_RD   = 2'd1;
    localparam logic [1:0] MEM_WR   = 2'd2;

    // write data select
    localparam logic [1:0] WD_I      = 2'd0;
    localparam logic [1:0] WD_I_DEC  = 2'd1;
    localparam logic [1:0] WD_DIFF   = 2'd2;

    // i counter operation
    localparam logic [1:0] IOP_HOLD = 2'd0;
    localparam logic [1:0] IOP_SET2 = 2'd1;
    localparam logic [1:0] IOP_INC  = 2'd2;

    // j counter operation
    localparam logic [1:0] JOP_HOLD  = 2'd0;
    localparam logic [1:0] JOP_SET2I = 2'd1;
    localparam logic [1:0] JOP_ADDI  = 2'd2;

    // jump conditions
    localparam logic [2:0] CND_NEVER     = 3'd0;
    localparam logic [2:0] CND_ALWAYS    = 3'd1;
    localparam logic [2:0] CND_I_NE_TOP  = 3'd2;
    localparam logic [2:0] CND_NOT_PRIME = 3'd3;
    localparam logic [2:0] CND_J_GT_TOP  = 3'd4;
    localparam logic [2:0] CND_DIV_BUSY  = 3'd5;

    // program steps
    localparam logic [ETT_STEP_W-1:0] STP_FILL  = 4'd0;
    localparam logic [ETT_STEP_W-1:0] STP_START = 4'd1;
    localparam logic [ETT_STEP_W-1:0] STP_RD_I  = 4'd2;
    localparam logic [ETT_STEP_W-1:0] STP_TEST  = 4'd3;
    localparam logic [ETT_STEP_W-1:0] STP_MARK  = 4'd4;
    localparam logic [ETT_STEP_W-1:0] STP_J_CHK = 4'd5;
    localparam logic [ETT_STEP_W-1:0] STP_DIV0  = 4'd6;
    localparam logic [ETT_STEP_W-1:0] STP_DIV   = 4'd7;
    localparam logic [ETT_STEP_W-1:0] STP_UPD   = 4'd8;
    localparam logic [ETT_STEP_W-1:0] STP_NEXT  = 4'd9;
    localparam logic [ETT_STEP_W-1:0] STP_DONE  = 4'd10;

    typedef struct packed {
        logic [1:0]            mem_op;
        logic                  addr_j;
        logic [1:0]            wsel;
        logic [1:0]            i_op;
        logic [1:0]            j_op;
        logic                  div_go;
        logic [2:0]            cond;
        logic [ETT_STEP_W-1:0] target;
        logic                  done;
    } t_ctl;

    function automatic t_ctl ett_ucode(input logic [ETT_STEP_W-1:0] step);
        t_ctl c;
        c = '{mem_op: MEM_NONE, addr_j: 1'b0, wsel: WD_I, i_op: IOP_HOLD,
              j_op: JOP_HOLD, div_go: 1'b0, cond: CND_ALWAYS, target: STP_DONE,
              done: 1'b0};
        case (step)
            STP_FILL: begin
                c.mem_op = MEM_WR;
                c.wsel   = WD_I;
                c.i_op   = IOP_INC;
                c.cond   = CND_I_NE_TOP;
                c.target = STP_FILL;
            end
            STP_START: begin
                c.i_op = IOP_SET2;
                c.cond = CND_NEVER;
            end
            STP_RD_I: begin
                c.mem_op = MEM_RD;
                c.cond   = CND_NEVER;
            end
            STP_TEST: begin
                c.cond   = CND_NOT_PRIME;
                c.target = STP_NEXT;
            end
            STP_MARK: begin
                c.mem_op = MEM_WR;
                c.wsel   = WD_I_DEC;
                c.j_op   = JOP_SET2I;
                c.cond   = CND_NEVER;
            end
            STP_J_CHK: begin
                c.mem_op = MEM_RD;
                c.addr_j = 1'b1;
                c.cond   = CND_J_GT_TOP;
                c.target = STP_NEXT;
            end
            STP_DIV0: begin
                c.div_go = 1'b1;
                c.cond   = CND_NEVER;
            end
            STP_DIV: begin
                c.cond   = CND_DIV_BUSY;
                c.target = STP_DIV;
            end
            STP_UPD: begin
                c.mem_op = MEM_WR;
                c.addr_j = 1'b1;
                c.wsel   = WD_DIFF;
                c.j_op   = JOP_ADDI;
                c.cond   = CND_ALWAYS;
                c.target = STP_J_CHK;
            end
            STP_NEXT: begin
                c.i_op   = IOP_INC;
                c.cond   = CND_I_NE_TOP;
                c.target = STP_RD_I;
            end
            STP_DONE: begin
                c.done   = 1'b1;
                c.cond   = CND_ALWAYS;
                c.target = STP_DONE;
            end
            default: begin
                c.cond   = CND_ALWAYS;
                c.target = STP_DONE;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/ett_if.sv =====
interface ett_query_if import ett_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [ETT_FIELD_W-1:0] query_number;

    modport source (output valid, output query_number, input ready);
    modport sink (input valid, input query_number, output ready);
endinterface

interface ett_result_if import ett_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [ETT_FIELD_W-1:0] coprime_count;
    logic                   out_of_range;

    modport source (output valid, output coprime_count, output out_of_range, input ready);
    modport sink (input valid, input coprime_count, input out_of_range, output ready);
endinterface

// ===== rtl/ett_ram.sv =====
module ett_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ett_divider.sv =====
module ett_divider #(
    parameter int W = 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_busy,
    output logic [W-1:0] o_quotient
);

    localparam int CNTW = $clog2(W + 1);

    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [W-1:0]    r_rem, n_rem;
    logic [W-1:0]    r_quo, n_quo;
    logic [W-1:0]    r_div, n_div;
    logic [W:0]      trial;
    logic [W:0]      diff;

    always_comb begin
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_quo = r_quo;
        n_div = r_div;
        trial = {r_rem, r_quo[W-1]};
        diff  = trial - {1'b0, r_div};
        if (i_start) begin
            n_cnt = CNTW'(W);
            n_rem = '0;
            n_quo = i_dividend;
            n_div = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (trial >= {1'b0, r_div}) begin
                n_rem = diff[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = trial[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule

// ===== rtl/euler_totient_table.sv =====
// after reset the table is built by a sieve before the first query is taken:
// each entry is filled with its index, then each prime i updates phi of its
// multiples with the divider; queries go through the ram read register and
// the output register, one query per cycle unless the result side stalls
// the build time is set by the one-port table ram and the bit-serial divider
// reset (synchronous, active low) clears the built flag and restarts the build
module euler_totient_table import ett_pkg::*; #(
    parameter int TABLE_TOP = ETT_TABLE_TOP
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ett_query_if.sink    i_query,
    ett_result_if.source o_result
);

    localparam int W  = $clog2(TABLE_TOP + 1);
    localparam int CW = W + 1;
    localparam int XW = (W > ETT_FIELD_W) ? W : ETT_FIELD_W;

    t_ctl                  ctl;
    logic [ETT_STEP_W-1:0] r_step, n_step;
    logic                  r_built;
    logic [CW-1:0]         r_i, n_i;
    logic [CW-1:0]         r_j, n_j;
    logic [W-1:0]          r_entry;
    logic                  jump;

    logic                  ram_we, ram_re;
    logic [W-1:0]          ram_addr, ram_wdata, ram_rdata;
    logic                  div_busy;
    logic [W-1:0]          quotient;

    logic                  in_acc, a_move;
    logic                  r_a_valid, r_a_oor;
    logic                  r_o_valid;
    logic [ETT_FIELD_W-1:0] r_o_count;
    logic                  r_o_oor;
    logic [XW-1:0]         q_ext, e_ext;
    logic                  q_oor;

    assign ctl = ett_ucode(r_step);

    always_comb begin
        case (ctl.cond)
            CND_NEVER:     jump = 1'b0;
            CND_ALWAYS:    jump = 1'b1;
            CND_I_NE_TOP:  jump = (r_i != CW'(TABLE_TOP));
            CND_NOT_PRIME: jump = (ram_rdata != r_i[W-1:0]);
            CND_J_GT_TOP:  jump = (r_j > CW'(TABLE_TOP));
            CND_DIV_BUSY:  jump = div_busy;
            default:       jump = 1'b0;
        endcase
        n_step = jump ? ctl.target : r_step + 1'b1;

        case (ctl.i_op)
            IOP_SET2: n_i = CW'(2);
            IOP_INC:  n_i = r_i + 1'b1;
            default:  n_i = r_i;
        endcase

        case (ctl.j_op)
            JOP_SET2I: n_j = {r_i[CW-2:0], 1'b0};
            JOP_ADDI:  n_j = r_j + r_i;
            default:   n_j = r_j;
        endcase

        case (ctl.wsel)
            WD_I:     ram_wdata = r_i[W-1:0];
            WD_I_DEC: ram_wdata = r_i[W-1:0] - 1'b1;
            WD_DIFF:  ram_wdata = r_entry - quotient;
            default:  ram_wdata = r_i[W-1:0];
        endcase
    end

    // query path
    assign q_ext  = XW'(i_query.query_number);
    assign q_oor  = (q_ext == '0) || (q_ext > XW'(TABLE_TOP));
    assign a_move = r_a_valid && (!r_o_valid || o_result.ready);
    assign i_query.ready = r_built && (!r_a_valid || a_move);
    assign in_acc = i_query.valid && i_query.ready;
    assign e_ext  = XW'(ram_rdata);

    assign ram_we   = !r_built && (ctl.mem_op == MEM_WR);
    assign ram_re   = r_built ? in_acc : (ctl.mem_op == MEM_RD);
    assign ram_addr = r_built ? q_ext[W-1:0] : (ctl.addr_j ? r_j[W-1:0] : r_i[W-1:0]);

    ett_ram #(
        .WIDTH (W),
        .DEPTH (TABLE_TOP + 1)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    ett_divider #(
        .W (W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctl.div_go && !r_built),
        .i_dividend (ram_rdata),
        .i_divisor  (r_i[W-1:0]),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= STP_FILL;
            r_built   <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (!r_built) begin
                r_step <= n_step;
                r_i    <= n_i;
                r_j    <= n_j;
                if (ctl.done) begin
                    r_built <= 1'b1;
                end
            end
            r_a_valid <= in_acc || (r_a_valid && !a_move);
            if (a_move) begin
                r_o_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_o_valid <= 1'b0;
            end
        end
        if (ctl.div_go) begin
            r_entry <= ram_rdata;
        end
        if (in_acc) begin
            r_a_oor <= q_oor;
        end
        if (a_move) begin
            r_o_oor   <= r_a_oor;
            r_o_count <= r_a_oor ? '0 : e_ext[ETT_FIELD_W-1:0];
        end
    end

    assign o_result.valid         = r_o_valid;
    assign o_result.coprime_count = r_o_count;
    assign o_result.out_of_range  = r_o_oor;

endmodule

// ===== rtl/ett_checker.sv =====
module ett_checker import ett_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [ETT_FIELD_W-1:0] i_coprime_count,
    input logic                   i_out_of_range
);

    a_no_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("query taken right after reset");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    a_result_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result with no query accepted before it");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_of_range) |-> (i_coprime_count == '0))
        else $error("out of range result with nonzero count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_coprime_count) && $stable(i_out_of_range)))
        else $error("stalled result beat changed");

endmodule

bind euler_totient_table ett_checker u_ett_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_query.valid),
    .i_in_ready      (i_query.ready),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_coprime_count (o_result.coprime_count),
    .i_out_of_range  (o_result.out_of_range)
);

// ===== bench/tb_euler_totient_table.sv =====
module tb_euler_totient_table;
    timeunit 1ns;
    timeprecision 1ps;

    import ett_pkg::*;

    localparam int TOP          = ETT_TABLE_TOP;
    localparam int FIELD_MAX    = (1 << ETT_FIELD_W) - 1;
    localparam int IDLE_PCT     = 24;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_PRINTED  = 100;

    typedef struct packed {
        logic [ETT_FIELD_W-1:0] query_number;
        logic [ETT_FIELD_W-1:0] coprime_count;
        logic                   out_of_range;
    } t_phi_answer;

    logic        i_clk;
    logic        i_rst_n;
    bit          steady_run;
    int          mismatch_count;
    int          cycle_count;
    int          phi_table [0:TOP];
    t_phi_answer pending_answers [$];

    ett_query_if  query_bus ();
    ett_result_if result_bus ();

    euler_totient_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_query  (query_bus),
        .o_result (result_bus)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void build_phi_table();
        int p;
        int m;
        phi_table[0] = 0;
        for (p = 1; p <= TOP; p++) phi_table[p] = p;
        for (p = 2; p <= TOP; p++) begin
            if (phi_table[p] == p) begin
                phi_table[p] = p - 1;
                for (m = 2 * p; m <= TOP; m += p) phi_table[m] = phi_table[m] * (p - 1) / p;
            end
        end
    endfunction

    function automatic t_phi_answer answer_for(logic [ETT_FIELD_W-1:0] q);
        t_phi_answer a;
        a.query_number = q;
        if (q == '0 || int'(q) > TOP) begin
            a.coprime_count = '0;
            a.out_of_range  = 1'b1;
        end else begin
            a.coprime_count = ETT_FIELD_W'(phi_table[q]);
            a.out_of_range  = 1'b0;
        end
        return a;
    endfunction

    task automatic report_mismatch(string what);
        if (mismatch_count < MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // caller is at a falling edge; returns at the falling edge after the beat
    task automatic send_query(logic [ETT_FIELD_W-1:0] q);
        while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
            query_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        query_bus.valid        <= 1'b1;
        query_bus.query_number <= q;
        do @(posedge i_clk); while (query_bus.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        result_bus.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_phi_answer want;
        if (i_rst_n) begin
            if (query_bus.valid === 1'b1 && query_bus.ready === 1'b1)
                pending_answers.push_back(answer_for(query_bus.query_number));
            if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
                if (pending_answers.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat count=%0d oor=%0b",
                        result_bus.coprime_count, result_bus.out_of_range));
                end else begin
                    want = pending_answers.pop_front();
                    if (result_bus.coprime_count !== want.coprime_count)
                        report_mismatch($sformatf("query %0d: count %0d, want %0d",
                            want.query_number, result_bus.coprime_count, want.coprime_count));
                    if (result_bus.out_of_range !== want.out_of_range)
                        report_mismatch($sformatf("query %0d: out_of_range %0b, want %0b",
                            want.query_number, result_bus.out_of_range, want.out_of_range));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // first query after reset waits for the sieve
    task automatic test_first_query();
        send_query(ETT_FIELD_W'(1));
    endtask

    task automatic test_boundaries();
        int picks [12] = '{0, 1, 2, TOP, TOP - 1, 0, FIELD_MAX, 341, 682, 512, 511, 1000};
        foreach (picks[k]) send_query(ETT_FIELD_W'(picks[k]));
    endtask

    task automatic test_primes_and_composites();
        int picks [12] = '{3, 4, 6, 30, 97, 256, 729, 997, 1021, 1019, 210, 840};
        foreach (picks[k]) send_query(ETT_FIELD_W'(picks[k]));
    endtask

    task automatic test_random_spread(int count);
        int r;
        int q;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 6) q = 0;
            else if (r < 14) q = $urandom_range(FIELD_MAX, 0);
            else if (r < 22) q = $urandom_range(TOP, (TOP > 40) ? TOP - 40 : 1);
            else q = $urandom_range((TOP < FIELD_MAX) ? TOP : FIELD_MAX, 1);
            send_query(ETT_FIELD_W'(q));
        end
    endtask

    // no idling on either side
    task automatic test_back_to_back(int count);
        steady_run = 1'b1;
        test_random_spread(count);
        steady_run = 1'b0;
    endtask

    initial begin
        i_rst_n                = 1'b0;
        query_bus.valid        = 1'b0;
        query_bus.query_number = '0;
        result_bus.ready       = 1'b0;
        steady_run             = 1'b0;
        mismatch_count         = 0;
        cycle_count            = 0;
        build_phi_table();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_first_query();
        test_boundaries();
        test_primes_and_composites();
        test_random_spread(300);
        test_back_to_back(250);
        test_random_spread(330);
        query_bus.valid <= 1'b0;

        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
